// ----- hw/rtl/u8u16_pkg.sv -----
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
   localparam logic [20:0] MAX_CODE     = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW     = 21'h00D800;
   localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h010000;
   localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
   localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
   localparam logic [15:0] LIMIT_RESET  = 16'd383;
   localparam int          MAX_UNITS    = 4;

   // sequence lengths decoded from a lead byte
   localparam logic [2:0] LEN_BAD  = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THR  = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   typedef struct packed {
      logic [23:0] pend_bytes;
      logic [1:0]  pend_count;
      logic [15:0] units;
      logic        stopped;
      logic        terminated;
   } dec_state_type;

   typedef struct packed {
      logic [MAX_UNITS-1:0][15:0] unit;
      logic [1:0]                 last_idx;
      logic                       has_unit;
      logic                       ended;
      logic [15:0]                base;
   } unit_group_type;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)           len = LEN_ONE;
      else if (b[7:5] == 3'b110)  len = LEN_TWO;
      else if (b[7:4] == 4'b1110) len = LEN_THR;
      else if (b[7:3] == 5'b11110) len = LEN_FOUR;
      else                        len = LEN_BAD;
      return len;
   endfunction

endpackage

// ----- hw/rtl/u8u16_step.sv -----
`timescale 1ns / 1ps

module u8u16_step (
   input  logic [7:0]               in_byte,
   input  logic                     last_byte,
   input  logic [15:0]              unit_limit,
   input  u8u16_pkg::dec_state_type state_cur,
   output u8u16_pkg::dec_state_type state_nxt,
   output u8u16_pkg::unit_group_type group,
   output logic                     produce
);

   always_comb begin
      logic [1:0]  pc;
      logic [23:0] pb;
      logic [15:0] e;
      logic        stp;
      logic        is_cont;
      logic [2:0]  blen;
      logic [2:0]  llen;
      logic [7:0]  lead;
      logic [31:0] acc;
      logic [20:0] cp;
      logic [20:0] v;
      logic [2:0]  k;
      logic        pair;
      logic [1:0]  spos;
      logic        sval;
      logic [15:0] sunit;
      logic [15:0] lo;
      logic [1:0]  npc;
      logic [23:0] npb;
      logic        ended;
      logic [16:0] room_w;
      logic [2:0]  room;
      logic [2:0]  m;

      // a new string starts clean after an end
      pc  = state_cur.terminated ? 2'd0 : state_cur.pend_count;
      pb  = state_cur.terminated ? 24'd0 : state_cur.pend_bytes;
      e   = state_cur.terminated ? 16'd0 : state_cur.units;
      stp = state_cur.terminated ? 1'b0 : state_cur.stopped;

      is_cont = (in_byte[7:6] == 2'b10);
      blen    = u8u16_pkg::seq_len(in_byte);
      case (pc)
         2'd2:    lead = pb[15:8];
         2'd3:    lead = pb[23:16];
         default: lead = pb[7:0];
      endcase
      llen = u8u16_pkg::seq_len(lead);
      acc  = {pb, in_byte};
      cp   = 21'd0;
      v    = 21'd0;

      k     = 3'd0;
      pair  = 1'b0;
      spos  = 2'd0;
      sval  = 1'b0;
      sunit = u8u16_pkg::REPL_CHAR;
      lo    = u8u16_pkg::REPL_CHAR;
      npc   = pc;
      npb   = pb;
      ended = 1'b0;

      if (in_byte == 8'd0) begin
         k     = {1'b0, pc};
         npc   = 2'd0;
         npb   = 24'd0;
         ended = 1'b1;
      end else if (pc != 2'd0 && is_cont) begin
         if ({1'b0, pc} + 3'd1 >= llen) begin
            npc = 2'd0;
            npb = 24'd0;
            unique case (llen)
               u8u16_pkg::LEN_TWO: cp = {10'd0, acc[12:8], acc[5:0]};
               u8u16_pkg::LEN_THR: cp = {5'd0, acc[19:16], acc[13:8], acc[5:0]};
               default:            cp = {acc[26:24], acc[21:16], acc[13:8], acc[5:0]};
            endcase
            sval = 1'b1;
            if (cp > u8u16_pkg::MAX_CODE ||
                (cp >= u8u16_pkg::SURR_LOW && cp <= u8u16_pkg::SURR_HIGH)) begin
               k = 3'd1;
            end else if (cp >= u8u16_pkg::SUPP_BASE) begin
               v     = cp - u8u16_pkg::SUPP_BASE;
               pair  = 1'b1;
               sunit = {u8u16_pkg::HI_SURR_TAG, v[19:10]};
               lo    = {u8u16_pkg::LO_SURR_TAG, v[9:0]};
               k     = 3'd2;
            end else begin
               sunit = cp[15:0];
               k     = 3'd1;
            end
         end else begin
            npb = acc[23:0];
            npc = pc + 2'd1;
         end
      end else begin
         // broken sequence flushes first, then the byte starts anew
         spos = pc;
         if (blen == u8u16_pkg::LEN_TWO || blen == u8u16_pkg::LEN_THR ||
             blen == u8u16_pkg::LEN_FOUR) begin
            k   = {1'b0, pc};
            npc = 2'd1;
            npb = {16'd0, in_byte};
         end else begin
            sval  = 1'b1;
            sunit = (blen == u8u16_pkg::LEN_ONE) ? {8'd0, in_byte} : u8u16_pkg::REPL_CHAR;
            k     = {1'b0, pc} + 3'd1;
            npc   = 2'd0;
            npb   = 24'd0;
         end
      end

      if (last_byte && !ended) begin
         k     = k + {1'b0, npc};
         npc   = 2'd0;
         npb   = 24'd0;
         ended = 1'b1;
      end

      for (int j = 0; j < u8u16_pkg::MAX_UNITS; j++) begin
         group.unit[j] = (sval && spos == 2'(j)) ? sunit : u8u16_pkg::REPL_CHAR;
      end
      if (pair) begin
         group.unit[1] = lo;
      end

      // room left under the limit, clamped to one group
      room_w = (unit_limit > e) ? ({1'b0, unit_limit} - {1'b0, e}) : 17'd0;
      room   = (room_w >= 17'd4) ? 3'd4 : room_w[2:0];
      if (stp)       m = 3'd0;
      else if (pair) m = (room >= 3'd2) ? 3'd2 : 3'd0;
      else           m = (k < room) ? k : room;

      group.has_unit = (m != 3'd0);
      group.last_idx = (m != 3'd0) ? 2'(m - 3'd1) : 2'd0;
      group.ended    = ended;
      group.base     = e;
      produce        = (m != 3'd0) || ended;

      state_nxt.pend_bytes = npb;
      state_nxt.pend_count = npc;
      state_nxt.units      = e + {13'd0, m};
      state_nxt.stopped    = stp | (m < k);
      state_nxt.terminated = ended;
   end

endmodule

// ----- hw/rtl/u8u16_drain.sv -----
`timescale 1ns / 1ps

module u8u16_drain (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  u8u16_pkg::unit_group_type group,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_code_unit,
   output logic                      rsp_has_unit,
   output logic                      rsp_last_of_item,
   output logic                      rsp_end_of_string,
   output logic [15:0]               rsp_total_units
);

   logic                      valid_ff;
   logic [1:0]                idx_ff;
   u8u16_pkg::unit_group_type grp_ff;
   logic                      pop;
   logic                      at_last;

   assign at_last = (idx_ff == grp_ff.last_idx);
   assign pop     = valid_ff && !rsp_stall;
   assign free    = !valid_ff || (pop && at_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (pop) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_has_unit      = grp_ff.has_unit;
   assign rsp_code_unit     = grp_ff.has_unit ? grp_ff.unit[idx_ff] : 16'd0;
   assign rsp_total_units   = grp_ff.has_unit ? (grp_ff.base + {14'd0, idx_ff} + 16'd1)
                                              : grp_ff.base;
   assign rsp_last_of_item  = at_last;
   assign rsp_end_of_string = at_last && grp_ff.ended;

endmodule

// ----- hw/rtl/utf8_to_utf16_transcoder_unit.sv -----
`timescale 1ns / 1ps
// a byte is held in the input register, decoded, and its results are held in the result register
// throughput: one byte per cycle while each byte gives at most one beat and the result side does not stall
// a byte giving n result beats (n up to 4) holds the result register until its final beat is taken
// reset: synchronous active high, clears pending bytes, counts and flags,
//   unit_limit returns to 383

module utf8_to_utf16_transcoder_unit (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   // code unit output channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_has_unit,
   output logic        rsp_last_of_item,
   output logic        rsp_end_of_string,
   output logic [15:0] rsp_total_units,
   // limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_unit_limit
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // decoder state and limit register
   u8u16_pkg::dec_state_type  state_ff;
   u8u16_pkg::dec_state_type  state_in;
   logic [15:0]               limit_ff;

   u8u16_pkg::unit_group_type group;
   logic                      produce;
   logic                      free;
   logic                      advance;
   logic                      req_take;

   // limit writes are always taken, the block is idle by contract
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= u8u16_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_unit_limit;
      end
   end

   // a byte leaves the input register when its results have a slot,
   // bytes that give no beat only touch the state
   assign advance   = in_valid_ff && (!produce || free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // single pass decode of the registered byte
   u8u16_step u_step (
      .in_byte    (in_byte_ff),
      .last_byte  (in_last_ff),
      .unit_limit (limit_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .group      (group),
      .produce    (produce)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register, hands out one unit per beat
   u8u16_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && produce),
      .group             (group),
      .free              (free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_has_unit      (rsp_has_unit),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_total_units   (rsp_total_units)
   );

   // a group never breaks off before its final beat
   a_group_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_item |=> rsp_valid)
      else $error("result group ended early");

   // string end only on a byte's final beat
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_last_of_item)
      else $error("end of string not on final beat");

   // a unit beat always counts itself
   a_count_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_unit |-> rsp_total_units != 16'd0)
      else $error("unit beat with zero count");

   // the stop flag clears only when a new string starts
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(state_ff.stopped) |-> $past(state_ff.terminated))
      else $error("stop flag cleared inside a string");

endmodule

// ----- sim/tb_utf8_to_utf16_transcoder_unit.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_unit;

   localparam int PHASES       = 6;
   localparam int PHASE_BYTES  = 62;
   localparam int SETTLE       = 16;       // settle wait after all units are back
   localparam int HOLD_AFTER   = 40;       // result beats seen before the long hold-off
   localparam int HOLD_CYCLES  = 200;
   localparam int IDLE_PCT     = 22;
   localparam int TIMEOUT_NS   = 2000000;
   localparam int DIR_COUNT    = 25;

   // unit limits per random phase, the largest, small ones and back to the reset value
   localparam logic [15:0] PHASE_LIMITS [PHASES] =
      '{16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd6, u8u16_pkg::LIMIT_RESET};

   // directed bytes, {last_byte, in_byte}
   localparam logic [8:0] DIRECTED [DIR_COUNT] = '{
      9'h07F,                             // top of ascii
      9'h0C0, 9'h080,                     // overlong form of zero
      9'h0ED, 9'h0A0, 9'h080,             // encoded surrogate becomes one fffd
      9'h0F0, 9'h09F, 9'h098, 9'h080,     // supplementary value, surrogate pair
      9'h0F4, 9'h090, 9'h080, 9'h080,     // above 10ffff becomes one fffd
      9'h080,                             // continuation with nothing pending
      9'h0FF,                             // byte that is never a lead
      9'h0F0, 9'h09F, 9'h098, 9'h0FF,     // three pending broken by a bad byte, four units
      9'h0E2, 9'h082, 9'h000,             // zero byte flushes two pending bytes
      9'h000,                             // empty string, end marker only
      9'h1C3                              // last byte on a lone lead, flushed
   };

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        has_unit;
      logic        last_of_item;
      logic        end_of_string;
      logic [15:0] total_units;
   } unit_beat_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // byte input channel
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte   = 8'h00;
   logic        req_last_byte = 1'b0;

   // code unit output channel
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_has_unit;
   logic        rsp_last_of_item;
   logic        rsp_end_of_string;
   logic [15:0] rsp_total_units;

   // limit register write port
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_unit_limit = 16'h0000;

   // stimulus and checking state
   byte_item_type  bytes_to_send[$];
   unit_beat_type  units_due[$];
   unit_beat_type  step_beats[$];
   logic [7:0]     str_bytes[$];
   int             errors      = 0;
   int             beats_taken = 0;
   int             hold_left   = 0;
   bit             hold_done   = 1'b0;
   bit             calm_phase  = 1'b0;

   // transcoder shadow state, as after reset
   logic [15:0] limit_shadow = u8u16_pkg::LIMIT_RESET;
   logic [23:0] pend_bytes   = '0;
   logic [1:0]  pend_count   = '0;
   logic [15:0] str_units    = '0;
   logic        str_stopped  = 1'b0;
   logic        str_done     = 1'b0;

   utf8_to_utf16_transcoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_has_unit      (rsp_has_unit),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_total_units   (rsp_total_units),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_unit_limit    (csr_unit_limit)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // expected unit stream
   // ---------------------------------------------------------------

   // sequence length from the lead byte, bad for continuations and f8..ff
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      casez (b)
         8'b0???????: return u8u16_pkg::LEN_ONE;
         8'b110?????: return u8u16_pkg::LEN_TWO;
         8'b1110????: return u8u16_pkg::LEN_THR;
         8'b11110???: return u8u16_pkg::LEN_FOUR;
         default:     return u8u16_pkg::LEN_BAD;
      endcase
   endfunction

   // one unit, unless the string is stopped or the limit is already reached
   function automatic void put_unit(input logic [15:0] u);
      if (str_stopped) return;
      if (str_units >= limit_shadow) begin
         str_stopped = 1'b1;
         return;
      end
      str_units = str_units + 16'd1;
      step_beats.push_back('{code_unit: u, has_unit: 1'b1, last_of_item: 1'b0,
                             end_of_string: 1'b0, total_units: str_units});
   endfunction

   // a code point: bmp unit, surrogate pair, or fffd for out of range values
   function automatic void put_code(input logic [20:0] cp);
      logic [19:0] off;
      if (cp > u8u16_pkg::MAX_CODE ||
          (cp >= u8u16_pkg::SURR_LOW && cp <= u8u16_pkg::SURR_HIGH))
         cp = {5'd0, u8u16_pkg::REPL_CHAR};
      if (cp < u8u16_pkg::SUPP_BASE) begin
         put_unit(cp[15:0]);
         return;
      end
      if (str_stopped) return;
      // a pair goes out whole or not at all
      if ({1'b0, str_units} + 17'd2 > {1'b0, limit_shadow}) begin
         str_stopped = 1'b1;
         return;
      end
      off = 20'(cp - u8u16_pkg::SUPP_BASE);
      put_unit({u8u16_pkg::HI_SURR_TAG, off[19:10]});
      put_unit({u8u16_pkg::LO_SURR_TAG, off[9:0]});
   endfunction

   function automatic void flush_pending();
      for (int i = 0; i < int'(pend_count); i++) put_unit(u8u16_pkg::REPL_CHAR);
      pend_bytes = '0;
      pend_count = '0;
   endfunction

   function automatic void start_seq(input logic [7:0] b);
      logic [2:0] len;
      len = lead_len(b);
      if (len == u8u16_pkg::LEN_ONE) begin
         put_code({13'd0, b});
      end else if (len == u8u16_pkg::LEN_BAD) begin
         put_unit(u8u16_pkg::REPL_CHAR);
      end else begin
         pend_bytes = {16'd0, b};
         pend_count = 2'd1;
      end
   endfunction

   // payload bits of a complete sequence, newest byte lowest
   function automatic logic [20:0] decode_seq(input logic [31:0] acc, input logic [2:0] len);
      if (len == u8u16_pkg::LEN_TWO)
         return {10'd0, acc[12:8], acc[5:0]};
      if (len == u8u16_pkg::LEN_THR)
         return {5'd0, acc[19:16], acc[13:8], acc[5:0]};
      return {acc[26:24], acc[21:16], acc[13:8], acc[5:0]};
   endfunction

   // all result beats caused by one accepted byte
   function automatic void transcode_byte(input logic [7:0] b, input logic lst);
      logic          ended;
      logic [7:0]    lead;
      logic [2:0]    len;
      logic [31:0]   acc;
      unit_beat_type tail;
      ended = 1'b0;
      step_beats.delete();
      // first byte after an end opens a new string
      if (str_done) begin
         str_units   = '0;
         str_stopped = 1'b0;
         pend_bytes  = '0;
         pend_count  = '0;
         str_done    = 1'b0;
      end
      if (b == 8'h00) begin
         flush_pending();
         ended = 1'b1;
      end else if (pend_count != 0) begin
         lead = 8'(pend_bytes >> (8 * (int'(pend_count) - 1)));
         len  = lead_len(lead);
         if (b[7:6] == 2'b10) begin
            acc = {pend_bytes, b};
            if (int'(pend_count) + 1 >= int'(len)) begin
               pend_bytes = '0;
               pend_count = '0;
               put_code(decode_seq(acc, len));
            end else begin
               pend_bytes = acc[23:0];
               pend_count = pend_count + 2'd1;
            end
         end else begin
            // broken sequence, then the byte starts anew
            flush_pending();
            start_seq(b);
         end
      end else begin
         start_seq(b);
      end
      if (lst && !ended) begin
         flush_pending();
         ended = 1'b1;
      end
      if (ended) begin
         str_done = 1'b1;
         if (step_beats.size() == 0)
            step_beats.push_back('{code_unit: 16'h0000, has_unit: 1'b0, last_of_item: 1'b0,
                                   end_of_string: 1'b0, total_units: str_units});
      end
      if (step_beats.size() != 0) begin
         tail = step_beats.pop_back();
         tail.last_of_item  = 1'b1;
         tail.end_of_string = ended;
         step_beats.push_back(tail);
      end
      foreach (step_beats[i]) units_due.push_back(step_beats[i]);
   endfunction

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------

   function automatic void push_byte(input logic [7:0] b, input logic lst);
      bytes_to_send.push_back('{data: b, last: lst});
   endfunction

   // one well-formed character with random payload, or its leading part when cut
   function automatic void add_char(input bit cut);
      logic [7:0] seqb [4];
      int kind;
      int len;
      int keep;
      kind = $urandom_range(9);
      if (kind < 4) begin
         len = 1;
         seqb[0] = 8'($urandom_range(1, 127));
      end else if (kind < 6) begin
         len = 2;
         seqb[0] = {3'b110, 5'($urandom)};
      end else if (kind < 8) begin
         len = 3;
         seqb[0] = {4'b1110, 4'($urandom)};
      end else begin
         len = 4;
         seqb[0] = {5'b11110, 3'($urandom)};
      end
      for (int i = 1; i < len; i++) seqb[i] = {2'b10, 6'($urandom)};
      keep = (cut && len > 1) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < keep; i++) str_bytes.push_back(seqb[i]);
   endfunction

   // random strings, mostly well formed, some cut short or hit by noise
   task automatic load_random(input int target);
      int added;
      int r;
      bit zero_end;
      bit fin;
      added = 0;
      while (added < target) begin
         str_bytes.delete();
         repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(99);
            if (r < 78)      add_char(1'b0);
            else if (r < 89) add_char(1'b1);
            else             str_bytes.push_back(8'($urandom));
         end
         zero_end = ($urandom_range(99) < 30);
         if (zero_end) str_bytes.push_back(8'h00);
         foreach (str_bytes[i]) begin
            fin = (i == str_bytes.size() - 1) && (!zero_end || $urandom_range(1));
            push_byte(str_bytes[i], fin);
         end
         added += str_bytes.size();
      end
   endtask

   // limit write while the block is idle
   task automatic write_limit(input logic [15:0] val);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_unit_limit <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      limit_shadow = val;
   endtask

   // all bytes taken, all units back, then a settle wait for bytes with no result
   task automatic wait_idle();
      while (bytes_to_send.size() != 0 || req_valid) @(posedge clock);
      while (units_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // byte driver: offers the next byte, holds it until taken
   // ---------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      byte_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            transcode_byte(req_in_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (bytes_to_send.size() != 0 &&
                (calm_phase || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = bytes_to_send.pop_front();
               req_valid     <= 1'b1;
               req_in_byte   <= nxt.data;
               req_last_byte <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result side stall: random, one long hold-off to back up the input
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_backpressure
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm_phase && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------
   // result monitor: every taken beat against the oldest expected one
   // ---------------------------------------------------------------
   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      unit_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_taken <= beats_taken + 1;
         if (units_due.size() == 0) begin
            $display("%0t ns: unexpected beat, expected none, actual unit %h has %b end %b",
                     $time, rsp_code_unit, rsp_has_unit, rsp_end_of_string);
            errors++;
         end else begin
            want = units_due.pop_front();
            check_field("code_unit", want.code_unit, rsp_code_unit);
            check_field("has_unit", 16'(want.has_unit), 16'(rsp_has_unit));
            check_field("last_of_item", 16'(want.last_of_item), 16'(rsp_last_of_item));
            check_field("end_of_string", 16'(want.end_of_string), 16'(rsp_end_of_string));
            check_field("total_units", want.total_units, rsp_total_units);
         end
      end
   end

   // ---------------------------------------------------------------
   // sequence: reset, directed bytes at the reset limit, random phases
   // ---------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) push_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         write_limit(PHASE_LIMITS[p]);
         // one phase runs with no idling on either side
         calm_phase = (p == 4);
         load_random(PHASE_BYTES);
         wait_idle();
         calm_phase = 1'b0;
      end

      if (errors == 0)
         $display("PASS utf8_to_utf16_transcoder_unit");
      else
         $display("FAIL utf8_to_utf16_transcoder_unit");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL utf8_to_utf16_transcoder_unit");
      $finish;
   end

endmodule
